[rtl/nnps_pkg.sv]
// Shared types and constants for the NCC nearest-neighbor patch scorer.
// No dependencies; imported by every module of the block.
package nnps_pkg;

  localparam int PATCH_HEIGHT_DEF  = 15;
  localparam int PATCH_WIDTH_DEF   = 15;
  localparam int MAX_TEMPLATES_DEF = 64;

  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 7;
  localparam int PIXEL_W  = 16;
  localparam int STATUS_W = 2;
  localparam int SCORE_W  = 16;
  localparam int IDX_W    = 7;

  localparam logic [SCORE_W-1:0] THRESH_RST = 16'd62259;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SLOT = 2'd2
  } status_e;

  // Command handed from the front end to the back end on a last pixel
  typedef struct packed {
    opcode_e             op;
    logic                is_pos;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;

  // Pixel write request from the front end into the pixel stores
  typedef struct packed {
    logic                tmpl_we;
    logic                smp_we;
    logic [PIXEL_W-1:0]  data;
  } pix_wr_t;

  typedef enum logic [4:0] {
    BS_IDLE,
    BS_DECODE,
    BS_TSHIFT_RD,
    BS_TSHIFT_WR,
    BS_TCOMMIT,
    BS_ORD_RD,
    BS_BASE,
    BS_MAC,
    BS_DRAIN,
    BS_SQRT_T,
    BS_SQRT_S,
    BS_LOWER,
    BS_DIVC,
    BS_DIV,
    BS_SIM,
    BS_RINIT,
    BS_RDIV
  } back_state_e;

endpackage

[rtl/nnps_front.sv]
// Front end: accepts pixel transactions, tracks the pixel position and issues
// pixel writes and end-of-patch commands. Depends on nnps_pkg.
module nnps_front import nnps_pkg::*; #(
  parameter int PATCH_HEIGHT  = PATCH_HEIGHT_DEF,
  parameter int PATCH_WIDTH   = PATCH_WIDTH_DEF,
  parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF,
  localparam int PP  = PATCH_HEIGHT * PATCH_WIDTH,
  localparam int PIW = $clog2(PP),
  localparam int CNW = $clog2(MAX_TEMPLATES + 1),
  localparam int SAW = $clog2(2 * MAX_TEMPLATES * PP)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic                is_positive_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [PIXEL_W-1:0]  pixel_value_i,
  input  logic                last_pixel_i,
  input  logic [CNW-1:0]      pos_count_i,
  input  logic [CNW-1:0]      neg_count_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  output pix_wr_t             wr_o,
  output logic [SAW-1:0]      tmpl_addr_o,
  output logic [PIW-1:0]      smp_addr_o
);

  localparam int PPW = $clog2(PP + 1);
  localparam logic [SAW-1:0] PP_S     = SAW'(PP);
  localparam logic [SAW-1:0] LIST_OFF = SAW'(MAX_TEMPLATES * PP);

  logic [PPW-1:0] pos_q, pos_d;
  logic           accept, valid_op, in_range;
  logic [CNW-1:0] cnt;
  opcode_e        op;

  // Classify the transaction
  assign accept   = start_i && !busy_i;
  assign op       = opcode_e'(opcode_i);
  assign valid_op = (op != OP_NONE);
  assign in_range = (pos_q < PPW'(PP));
  assign cnt      = is_positive_i ? pos_count_i : neg_count_i;

  // Pixel writes into the template store or the sample buffer
  assign wr_o.tmpl_we = accept && valid_op && (op != OP_SAMPLE) && in_range &&
                        (cnt < CNW'(MAX_TEMPLATES));
  assign wr_o.smp_we  = accept && (op == OP_SAMPLE) && in_range;
  assign wr_o.data    = pixel_value_i;
  assign tmpl_addr_o  = (is_positive_i ? '0 : LIST_OFF) + SAW'(cnt) * PP_S + SAW'(pos_q);
  assign smp_addr_o   = pos_q[PIW-1:0];

  // End of patch goes to the command queue
  assign push_o      = accept && valid_op && last_pixel_i;
  assign cmd_o.op     = op;
  assign cmd_o.is_pos = is_positive_i;
  assign cmd_o.slot   = slot_i;

  // Pixel position counter
  always_comb begin
    pos_d = pos_q;
    if (accept && valid_op) begin
      if (last_pixel_i) begin
        pos_d = '0;
      end else if (in_range) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/nnps_cmd_fifo.sv]
// Two-entry command queue between the front end and the back end.
// Depends on nnps_pkg for the command type.
module nnps_cmd_fifo import nnps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign cmd_o   = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

endmodule

[rtl/nnps_back.sv]
// Back end: template order tables, pixel stores, NCC datapath with iterative
// square root and dividers, and result registers. Depends on nnps_pkg.
module nnps_back import nnps_pkg::*; #(
  parameter int PATCH_HEIGHT  = PATCH_HEIGHT_DEF,
  parameter int PATCH_WIDTH   = PATCH_WIDTH_DEF,
  parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF,
  localparam int PP  = PATCH_HEIGHT * PATCH_WIDTH,
  localparam int PIW = $clog2(PP),
  localparam int CNW = $clog2(MAX_TEMPLATES + 1),
  localparam int SAW = $clog2(2 * MAX_TEMPLATES * PP)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SCORE_W-1:0]  thr_i,
  input  cmd_t                cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  pix_wr_t             wr_i,
  input  logic [SAW-1:0]      tmpl_addr_i,
  input  logic [PIW-1:0]      smp_addr_i,
  output logic [CNW-1:0]      pos_count_o,
  output logic [CNW-1:0]      neg_count_o,
  output logic                busy_o,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SCORE_W-1:0]  rel_o,
  output logic [SCORE_W-1:0]  cons_o,
  output logic                in_pos_o,
  output logic                in_neg_o,
  output logic [IDX_W-1:0]    closest_o
);

  localparam int PPW  = $clog2(PP + 1);
  localparam int TW   = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam int NTW  = 31 + $clog2(PP);
  localparam int CRW  = NTW + 1;
  localparam int SQW  = ((NTW + 21) / 2) * 2;
  localparam int RW   = SQW / 2;
  localparam int CMPW = (SLOT_W > CNW) ? SLOT_W : CNW;
  localparam logic [SAW-1:0] PP_S     = SAW'(PP);
  localparam logic [SAW-1:0] LIST_OFF = SAW'(MAX_TEMPLATES * PP);
  localparam logic [SQW-1:0] TOPB     = SQW'(1) << (SQW - 2);
  localparam logic [16:0]    ONE17    = 17'h10000;
  localparam logic [17:0]    ONE18    = 18'h10000;

  // Memories
  logic signed [PIXEL_W-1:0] store_mem  [2 * MAX_TEMPLATES * PP];
  logic signed [PIXEL_W-1:0] sample_mem [PP];
  logic [TW-1:0]             order_mem  [2 * MAX_TEMPLATES];

  logic signed [PIXEL_W-1:0] store_rd_q, smp_rd_q;
  logic [TW-1:0]             ord_rd_q;
  logic                      ord_we;
  logic [TW:0]               ord_waddr, ord_raddr;
  logic [TW-1:0]             ord_wdata;
  logic [SAW-1:0]            mac_addr;

  // Control and datapath registers
  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CNW-1:0]    pcnt_q, pcnt_d, ncnt_q, ncnt_d, idx_q, idx_d, idx_all_q, idx_all_d;
  logic [TW-1:0]     at_q, at_d;
  logic              list_q, list_d, sel_q, sel_d, neg_q, neg_d;
  logic [SAW-1:0]    base_q, base_d;
  logic [PPW-1:0]    k_q, k_d;
  logic              rv_q, pv_q, issue;
  logic signed [31:0] pab_q, paa_q, pbb_q;
  logic signed [CRW-1:0] corr_q, corr_d;
  logic [NTW-1:0]    nt_q, nt_d, ns_q, ns_d;
  logic [SQW-1:0]    sx_q, sx_d, sr_q, sr_d, sb_q, sb_d;
  logic [RW-1:0]     rt_q, rt_d, rs_q, rs_d;
  logic [SQW-1:0]    lower_q, lower_d;
  logic [SQW:0]      rem_q, rem_d;
  logic [15:0]       f_q, f_d;
  logic [4:0]        step_q, step_d;
  logic [16:0]       n_q, n_d, best_q, best_d, bp_q, bp_d, bh_q, bh_d, bn_q, bn_d;
  logic [17:0]       den_q, den_d;
  logic [18:0]       rrem_q, rrem_d;
  logic [16:0]       qt_q, qt_d;
  logic              done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SCORE_W-1:0] rel_q, rel_d, cons_q, cons_d;
  logic              inpos_q, inpos_d, inneg_q, inneg_d;
  logic [IDX_W-1:0]  closest_q, closest_d;

  // Helper combinational terms
  logic [CNW-1:0]    tcnt, size, half;
  logic              tlist, is_ins;
  logic [SQW-1:0]    sq_t, x_n, r_n, b_n, num;
  logic [NTW-1:0]    mag;
  logic [SQW:0]      rem2;
  logic              dbit, rbit, fin;
  logic [15:0]       f_n;
  logic [17:0]       simsum;
  logic [16:0]       sim, nb, dn, dsel, q_n;
  logic [17:0]       den_n;
  logic [18:0]       r2;
  logic [SCORE_W-1:0] score;
  logic signed [31:0] prod_ab, prod_aa, prod_bb;

  assign pos_count_o = pcnt_q;
  assign neg_count_o = ncnt_q;
  assign busy_o      = (state_q != BS_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign rel_o       = rel_q;
  assign cons_o      = cons_q;
  assign in_pos_o    = inpos_q;
  assign in_neg_o    = inneg_q;
  assign closest_o   = closest_q;

  assign tlist  = cmd_q.is_pos;
  assign is_ins = (cmd_q.op == OP_INSERT);
  assign tcnt   = tlist ? pcnt_q : ncnt_q;
  assign size   = list_q ? pcnt_q : ncnt_q;
  assign half   = CNW'(({1'b0, pcnt_q} + 1'b1) >> 1);
  assign mac_addr = base_q + SAW'(k_q);

  // Square root step: one result bit per cycle
  always_comb begin
    sq_t = sr_q + sb_q;
    if (sx_q >= sq_t) begin
      x_n = sx_q - sq_t;
      r_n = (sr_q >> 1) + sb_q;
    end else begin
      x_n = sx_q;
      r_n = sr_q >> 1;
    end
    b_n = sb_q >> 2;
  end

  // Correlation magnitude and restoring divide step
  assign mag  = corr_q[CRW-1] ? NTW'(-corr_q) : NTW'(corr_q);
  assign num  = SQW'(mag) << 20;
  assign rem2 = {rem_q[SQW-1:0], 1'b0};
  assign dbit = (rem2 >= {1'b0, lower_q});
  assign f_n  = {f_q[14:0], dbit};

  // Similarity from the normalized correlation
  assign simsum = neg_q ? (ONE18 - {1'b0, n_q}) : (ONE18 + {1'b0, n_q});
  assign sim    = simsum[17:1];
  assign nb     = (sim > best_q) ? sim : best_q;

  // Score divider terms
  assign dn    = ONE17 - bn_q;
  assign dsel  = sel_q ? (ONE17 - bh_q) : (ONE17 - bp_q);
  assign den_n = {1'b0, dsel} + {1'b0, dn};
  assign r2    = (step_q == 5'd0) ? rrem_q : {rrem_q[17:0], 1'b0};
  assign rbit  = (r2 >= {1'b0, den_q});
  assign q_n   = {qt_q[15:0], rbit};

  // Products of the MAC pipeline
  assign prod_ab = store_rd_q * smp_rd_q;
  assign prod_aa = store_rd_q * store_rd_q;
  assign prod_bb = smp_rd_q * smp_rd_q;

  // Next state and datapath
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pcnt_d    = pcnt_q;
    ncnt_d    = ncnt_q;
    idx_d     = idx_q;
    idx_all_d = idx_all_q;
    at_d      = at_q;
    list_d    = list_q;
    sel_d     = sel_q;
    neg_d     = neg_q;
    base_d    = base_q;
    k_d       = k_q;
    corr_d    = corr_q;
    nt_d      = nt_q;
    ns_d      = ns_q;
    sx_d      = sx_q;
    sr_d      = sr_q;
    sb_d      = sb_q;
    rt_d      = rt_q;
    rs_d      = rs_q;
    lower_d   = lower_q;
    rem_d     = rem_q;
    f_d       = f_q;
    step_d    = step_q;
    n_d       = n_q;
    best_d    = best_q;
    bp_d      = bp_q;
    bh_d      = bh_q;
    bn_d      = bn_q;
    den_d     = den_q;
    rrem_d    = rrem_q;
    qt_d      = qt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    rel_d     = rel_q;
    cons_d    = cons_q;
    inpos_d   = inpos_q;
    inneg_d   = inneg_q;
    closest_d = closest_q;
    pop_o     = 1'b0;
    issue     = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    ord_raddr = '0;
    fin       = 1'b0;
    score     = '0;

    // Accumulate registered products
    if (pv_q) begin
      corr_d = corr_q + CRW'(pab_q);
      nt_d   = nt_q + NTW'(paa_q);
      ns_d   = ns_q + NTW'(pbb_q);
    end

    unique case (state_q)
      BS_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = BS_DECODE;
        end
      end
      BS_DECODE: begin
        status_d  = ST_OK;
        rel_d     = '0;
        cons_d    = '0;
        inpos_d   = 1'b0;
        inneg_d   = 1'b0;
        closest_d = '0;
        if (cmd_q.op == OP_SAMPLE) begin
          list_d    = 1'b1;
          idx_d     = '0;
          best_d    = '0;
          idx_all_d = pcnt_q;
          if (pcnt_q == '0) begin
            done_d  = 1'b1;
            state_d = BS_IDLE;
          end else if (ncnt_q == '0) begin
            rel_d   = '1;
            cons_d  = '1;
            done_d  = 1'b1;
            state_d = BS_IDLE;
          end else begin
            state_d = BS_ORD_RD;
          end
        end else if (tcnt >= CNW'(MAX_TEMPLATES)) begin
          status_d = ST_FULL;
          done_d   = 1'b1;
          state_d  = BS_IDLE;
        end else if (is_ins && (CMPW'(cmd_q.slot) > CMPW'(tcnt))) begin
          status_d = ST_SLOT;
          done_d   = 1'b1;
          state_d  = BS_IDLE;
        end else begin
          at_d  = is_ins ? TW'(CMPW'(cmd_q.slot)) : TW'(tcnt);
          idx_d = tcnt;
          if (is_ins && (CMPW'(cmd_q.slot) < CMPW'(tcnt))) begin
            state_d = BS_TSHIFT_RD;
          end else begin
            state_d = BS_TCOMMIT;
          end
        end
      end
      // Shift the order table up by one entry: read in BS_TSHIFT_RD, write in BS_TSHIFT_WR
      BS_TSHIFT_RD: begin
        ord_raddr = {tlist, TW'(idx_q - 1'b1)};
        state_d   = BS_TSHIFT_WR;
      end
      BS_TSHIFT_WR: begin
        ord_we    = 1'b1;
        ord_waddr = {tlist, TW'(idx_q)};
        ord_wdata = ord_rd_q;
        idx_d     = idx_q - 1'b1;
        if ((idx_q - 1'b1) > CNW'(at_q)) begin
          state_d = BS_TSHIFT_RD;
        end else begin
          state_d = BS_TCOMMIT;
        end
      end
      BS_TCOMMIT: begin
        ord_we    = 1'b1;
        ord_waddr = {tlist, at_q};
        ord_wdata = TW'(tcnt);
        if (tlist) pcnt_d = pcnt_q + 1'b1;
        else       ncnt_d = ncnt_q + 1'b1;
        status_d = ST_OK;
        done_d   = 1'b1;
        state_d  = BS_IDLE;
      end
      // Per-template scoring
      BS_ORD_RD: begin
        ord_raddr = {list_q, TW'(idx_q)};
        state_d   = BS_BASE;
      end
      BS_BASE: begin
        base_d  = (list_q ? '0 : LIST_OFF) + SAW'(ord_rd_q) * PP_S;
        k_d     = '0;
        corr_d  = '0;
        nt_d    = '0;
        ns_d    = '0;
        state_d = BS_MAC;
      end
      BS_MAC: begin
        issue = 1'b1;
        k_d   = k_q + 1'b1;
        if (k_q == PPW'(PP - 1)) state_d = BS_DRAIN;
      end
      BS_DRAIN: begin
        if (!rv_q && !pv_q) begin
          sx_d    = SQW'(nt_q) << 20;
          sr_d    = '0;
          sb_d    = TOPB;
          state_d = BS_SQRT_T;
        end
      end
      BS_SQRT_T: begin
        sx_d = x_n;
        sr_d = r_n;
        sb_d = b_n;
        if (sb_q == SQW'(1)) begin
          rt_d    = RW'(r_n);
          sx_d    = SQW'(ns_q) << 20;
          sr_d    = '0;
          sb_d    = TOPB;
          state_d = BS_SQRT_S;
        end
      end
      BS_SQRT_S: begin
        sx_d = x_n;
        sr_d = r_n;
        sb_d = b_n;
        if (sb_q == SQW'(1)) begin
          rs_d    = RW'(r_n);
          state_d = BS_LOWER;
        end
      end
      BS_LOWER: begin
        lower_d = SQW'(rt_q) * SQW'(rs_q);
        state_d = BS_DIVC;
      end
      BS_DIVC: begin
        if (lower_q == '0) begin
          // zero norm: similarity one half
          n_d     = '0;
          neg_d   = 1'b0;
          state_d = BS_SIM;
        end else if (num >= lower_q) begin
          n_d     = ONE17;
          neg_d   = corr_q[CRW-1];
          state_d = BS_SIM;
        end else begin
          rem_d   = {1'b0, num};
          f_d     = '0;
          step_d  = '0;
          neg_d   = corr_q[CRW-1];
          state_d = BS_DIV;
        end
      end
      BS_DIV: begin
        rem_d  = dbit ? (rem2 - {1'b0, lower_q}) : rem2;
        f_d    = f_n;
        step_d = step_q + 1'b1;
        if (step_q == 5'd15) begin
          n_d     = {1'b0, f_n};
          state_d = BS_SIM;
        end
      end
      BS_SIM: begin
        best_d = nb;
        if (list_q && (sim > best_q)) idx_all_d = idx_q + 1'b1;
        if (list_q && ((idx_q + 1'b1) == half)) bh_d = nb;
        idx_d = idx_q + 1'b1;
        if ((idx_q + 1'b1) < size) begin
          state_d = BS_ORD_RD;
        end else if (list_q) begin
          bp_d    = nb;
          list_d  = 1'b0;
          idx_d   = '0;
          best_d  = '0;
          state_d = BS_ORD_RD;
        end else begin
          bn_d    = nb;
          sel_d   = 1'b0;
          state_d = BS_RINIT;
        end
      end
      // Score division, relative then conservative
      BS_RINIT: begin
        den_d = den_n;
        if (den_n == '0) begin
          fin = 1'b1;
        end else begin
          rrem_d  = {2'b00, dn};
          qt_d    = '0;
          step_d  = '0;
          state_d = BS_RDIV;
        end
      end
      BS_RDIV: begin
        rrem_d = rbit ? (r2 - {1'b0, den_q}) : r2;
        qt_d   = q_n;
        step_d = step_q + 1'b1;
        if (step_q == 5'd16) begin
          fin   = 1'b1;
          score = q_n[16] ? '1 : q_n[15:0];
        end
      end
      default: state_d = BS_IDLE;
    endcase

    // Finish one score division
    if (fin) begin
      if (!sel_q) begin
        rel_d   = score;
        sel_d   = 1'b1;
        state_d = BS_RINIT;
      end else begin
        cons_d    = score;
        inpos_d   = (bp_q > {1'b0, thr_i});
        inneg_d   = (bn_q > {1'b0, thr_i});
        closest_d = IDX_W'(idx_all_q);
        status_d  = ST_OK;
        done_d    = 1'b1;
        state_d   = BS_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      pcnt_q  <= '0;
      ncnt_q  <= '0;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pcnt_q  <= pcnt_d;
      ncnt_q  <= ncnt_d;
      rv_q    <= issue;
      pv_q    <= rv_q;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    idx_all_q <= idx_all_d;
    at_q      <= at_d;
    list_q    <= list_d;
    sel_q     <= sel_d;
    neg_q     <= neg_d;
    base_q    <= base_d;
    k_q       <= k_d;
    corr_q    <= corr_d;
    nt_q      <= nt_d;
    ns_q      <= ns_d;
    sx_q      <= sx_d;
    sr_q      <= sr_d;
    sb_q      <= sb_d;
    rt_q      <= rt_d;
    rs_q      <= rs_d;
    lower_q   <= lower_d;
    rem_q     <= rem_d;
    f_q       <= f_d;
    step_q    <= step_d;
    n_q       <= n_d;
    best_q    <= best_d;
    bp_q      <= bp_d;
    bh_q      <= bh_d;
    bn_q      <= bn_d;
    den_q     <= den_d;
    rrem_q    <= rrem_d;
    qt_q      <= qt_d;
    status_q  <= status_d;
    rel_q     <= rel_d;
    cons_q    <= cons_d;
    inpos_q   <= inpos_d;
    inneg_q   <= inneg_d;
    closest_q <= closest_d;
    if (rv_q) begin
      pab_q <= prod_ab;
      paa_q <= prod_aa;
      pbb_q <= prod_bb;
    end
  end

  // Pixel stores: write from the front end, registered read for the MAC
  always_ff @(posedge clk_i) begin
    if (wr_i.tmpl_we) store_mem[tmpl_addr_i] <= wr_i.data;
    store_rd_q <= store_mem[mac_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.smp_we) sample_mem[smp_addr_i] <= wr_i.data;
    smp_rd_q <= sample_mem[k_q[PIW-1:0]];
  end

  // Order tables, both lists in one memory
  always_ff @(posedge clk_i) begin
    if (ord_we) order_mem[ord_waddr] <= ord_wdata;
    ord_rd_q <= order_mem[ord_raddr];
  end

endmodule

[rtl/ncc_nearest_neighbor_patch_scorer_unit.sv]
// Top level of the NCC nearest-neighbor patch scorer: front end, command queue,
// back end and threshold register. Depends on nnps_pkg. A non-last pixel goes only
// to the pixel stores. Last template pixel: queue, decode, order table shift (insert),
// commit. Last sample pixel: each stored template is scored, then both score divides
// run; busy_o holds input, results cannot stall.
// Reset clears counts, pixel position and threshold; stores need no clearing.
module ncc_nearest_neighbor_patch_scorer_unit import nnps_pkg::*; #(
  parameter int PATCH_HEIGHT  = PATCH_HEIGHT_DEF,
  parameter int PATCH_WIDTH   = PATCH_WIDTH_DEF,
  parameter int MAX_TEMPLATES = MAX_TEMPLATES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic                is_positive_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [PIXEL_W-1:0]  pixel_value_i,
  input  logic                last_pixel_i,
  input  logic                membership_threshold_we_i,
  input  logic [SCORE_W-1:0]  membership_threshold_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SCORE_W-1:0]  relative_score_o,
  output logic [SCORE_W-1:0]  conservative_score_o,
  output logic                in_positive_o,
  output logic                in_negative_o,
  output logic [IDX_W-1:0]    closest_index_o
);

  localparam int PP  = PATCH_HEIGHT * PATCH_WIDTH;
  localparam int PIW = $clog2(PP);
  localparam int CNW = $clog2(MAX_TEMPLATES + 1);
  localparam int SAW = $clog2(2 * MAX_TEMPLATES * PP);

  logic [SCORE_W-1:0] thr_q;
  logic               push, pop, empty, back_busy;
  cmd_t               cmd_in, cmd_out;
  pix_wr_t            wr;
  logic [SAW-1:0]     tmpl_addr;
  logic [PIW-1:0]     smp_addr;
  logic [CNW-1:0]     pcnt, ncnt;

  // Hold off new transactions while a command is pending or running
  assign busy_o = !empty || back_busy;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RST;
    end else if (membership_threshold_we_i) begin
      thr_q <= membership_threshold_i;
    end
  end

  nnps_front #(
    .PATCH_HEIGHT (PATCH_HEIGHT),
    .PATCH_WIDTH  (PATCH_WIDTH),
    .MAX_TEMPLATES(MAX_TEMPLATES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .opcode_i     (opcode_i),
    .is_positive_i(is_positive_i),
    .slot_i       (slot_i),
    .pixel_value_i(pixel_value_i),
    .last_pixel_i (last_pixel_i),
    .pos_count_i  (pcnt),
    .neg_count_i  (ncnt),
    .push_o       (push),
    .cmd_o        (cmd_in),
    .wr_o         (wr),
    .tmpl_addr_o  (tmpl_addr),
    .smp_addr_o   (smp_addr)
  );

  nnps_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .empty_o(empty)
  );

  nnps_back #(
    .PATCH_HEIGHT (PATCH_HEIGHT),
    .PATCH_WIDTH  (PATCH_WIDTH),
    .MAX_TEMPLATES(MAX_TEMPLATES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .thr_i      (thr_q),
    .cmd_i      (cmd_out),
    .empty_i    (empty),
    .pop_o      (pop),
    .wr_i       (wr),
    .tmpl_addr_i(tmpl_addr),
    .smp_addr_i (smp_addr),
    .pos_count_o(pcnt),
    .neg_count_o(ncnt),
    .busy_o     (back_busy),
    .done_o     (result_valid_o),
    .status_o   (status_o),
    .rel_o      (relative_score_o),
    .cons_o     (conservative_score_o),
    .in_pos_o   (in_positive_o),
    .in_neg_o   (in_negative_o),
    .closest_o  (closest_index_o)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for ncc_nearest_neighbor_patch_scorer_unit.
// Drives template and sample patches and predicts every result in-line.
// Depends on nnps_pkg and the scorer RTL.
module tb_top;
  import nnps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PP         = PATCH_HEIGHT_DEF * PATCH_WIDTH_DEF;
  localparam int MT         = MAX_TEMPLATES_DEF;
  localparam int IDLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 60;

  // Pixel patterns for template and sample patches
  localparam int PAT_RANDOM = 0;
  localparam int PAT_ZERO   = 1;
  localparam int PAT_MAX    = 2;
  localparam int PAT_MIN    = 3;
  localparam int PAT_SMALL  = 4;
  localparam int PAT_RAMP   = 5;
  localparam int PAT_NRAMP  = 6;

  typedef struct {
    status_e           status;
    logic [SCORE_W-1:0] rel;
    logic [SCORE_W-1:0] cons;
    logic              in_pos;
    logic              in_neg;
    logic [IDX_W-1:0]  idx;
  } score_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [OPCODE_W-1:0] opcode_i = '0;
  logic                is_positive_i = 1'b0;
  logic [SLOT_W-1:0]   slot_i = '0;
  logic [PIXEL_W-1:0]  pixel_value_i = '0;
  logic                last_pixel_i = 1'b0;
  logic                membership_threshold_we_i = 1'b0;
  logic [SCORE_W-1:0]  membership_threshold_i = '0;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [SCORE_W-1:0]  relative_score_o;
  logic [SCORE_W-1:0]  conservative_score_o;
  logic                in_positive_o;
  logic                in_negative_o;
  logic [IDX_W-1:0]    closest_index_o;

  // Predictor state
  logic signed [PIXEL_W-1:0] pos_store [MT*PP];
  logic signed [PIXEL_W-1:0] neg_store [MT*PP];
  logic signed [PIXEL_W-1:0] smp_store [PP];
  int                        pos_ord [MT];
  int                        neg_ord [MT];
  int                        pos_cnt, neg_cnt, pix_pos;
  logic [SCORE_W-1:0]        thresh;

  score_t expected_scores [$];
  int     mismatches;
  int     items_sent;
  int     idle_cycles;
  bit     gaps_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ncc_nearest_neighbor_patch_scorer_unit u_dut (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .start_i                   (start_i),
    .busy_o                    (busy_o),
    .opcode_i                  (opcode_i),
    .is_positive_i             (is_positive_i),
    .slot_i                    (slot_i),
    .pixel_value_i             (pixel_value_i),
    .last_pixel_i              (last_pixel_i),
    .membership_threshold_we_i (membership_threshold_we_i),
    .membership_threshold_i    (membership_threshold_i),
    .result_valid_o            (result_valid_o),
    .status_o                  (status_o),
    .relative_score_o          (relative_score_o),
    .conservative_score_o      (conservative_score_o),
    .in_positive_o             (in_positive_o),
    .in_negative_o             (in_negative_o),
    .closest_index_o           (closest_index_o)
  );

  // Floor square root, bit by bit
  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // (ncc + 1) / 2 in Q1.16 between the sample and one physical template
  function automatic int ncc_similarity(bit pos, int phys);
    longint    corr, a, b;
    bit [63:0] nt, ns, lower, mag, num, rem;
    int        n;
    corr = 0;
    nt = '0;
    ns = '0;
    for (int k = 0; k < PP; k++) begin
      a = pos ? pos_store[phys*PP+k] : neg_store[phys*PP+k];
      b = smp_store[k];
      corr += a * b;
      nt += 64'(a * a);
      ns += 64'(b * b);
    end
    lower = floor_sqrt(nt << 20) * floor_sqrt(ns << 20);
    if (lower == 0) return 32768;
    mag = (corr < 0) ? 64'(-corr) : 64'(corr);
    num = mag << 20;
    if (num >= lower) begin
      n = 65536;
    end else begin
      rem = num;
      n = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        n = n << 1;
        if (rem >= lower) begin
          rem = rem - lower;
          n = n | 1;
        end
      end
    end
    return (corr >= 0) ? (65536 + n) / 2 : (65536 - n) / 2;
  endfunction

  function automatic logic [SCORE_W-1:0] dist_ratio(int dn, int dp);
    bit [63:0] den, q;
    den = 64'(dp) + 64'(dn);
    if (den == 0) return '0;
    q = (64'(dn) << 16) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Advance the predictor by one accepted transaction
  task automatic predict_item(opcode_e op, bit pos, logic [SLOT_W-1:0] slot,
                              logic [PIXEL_W-1:0] pix, bit last);
    int     cnt, at, s, bp, bh, bn, ip, half;
    score_t r;
    if (op == OP_NONE) return;
    cnt = pos ? pos_cnt : neg_cnt;
    if (pix_pos < PP) begin
      if (op != OP_SAMPLE) begin
        if (cnt < MT) begin
          if (pos) pos_store[cnt*PP+pix_pos] = pix;
          else neg_store[cnt*PP+pix_pos] = pix;
        end
      end else begin
        smp_store[pix_pos] = pix;
      end
      pix_pos++;
    end
    if (!last) return;
    pix_pos = 0;
    r = '{ST_OK, '0, '0, 1'b0, 1'b0, '0};
    if (op != OP_SAMPLE) begin
      if (cnt >= MT) begin
        r.status = ST_FULL;
      end else if (op == OP_INSERT && slot > cnt) begin
        r.status = ST_SLOT;
      end else begin
        at = (op == OP_INSERT) ? int'(slot) : cnt;
        for (int j = cnt; j > at; j--) begin
          if (pos) pos_ord[j] = pos_ord[j-1];
          else neg_ord[j] = neg_ord[j-1];
        end
        if (pos) begin
          pos_ord[at] = cnt;
          pos_cnt++;
        end else begin
          neg_ord[at] = cnt;
          neg_cnt++;
        end
      end
    end else if (pos_cnt != 0 && neg_cnt == 0) begin
      r.rel = 16'hFFFF;
      r.cons = 16'hFFFF;
    end else if (pos_cnt != 0) begin
      bp = 0;
      bh = 0;
      bn = 0;
      ip = pos_cnt;
      half = (pos_cnt + 1) / 2;
      for (int i = 0; i < pos_cnt; i++) begin
        s = ncc_similarity(1'b1, pos_ord[i]);
        if (s > bp) begin
          bp = s;
          ip = i + 1;
        end
        if (i < half && s > bh) bh = s;
      end
      for (int i = 0; i < neg_cnt; i++) begin
        s = ncc_similarity(1'b0, neg_ord[i]);
        if (s > bn) bn = s;
      end
      r.rel = dist_ratio(65536 - bn, 65536 - bp);
      r.cons = dist_ratio(65536 - bn, 65536 - bh);
      r.in_pos = (bp > int'(thresh));
      r.in_neg = (bn > int'(thresh));
      r.idx = ip[IDX_W-1:0];
    end
    expected_scores = {expected_scores, r};
  endtask

  // Send one transaction; called and returns at a rising edge
  task automatic send_item(opcode_e op, bit pos, logic [SLOT_W-1:0] slot,
                           logic [PIXEL_W-1:0] pix, bit last);
    while (gaps_on && $urandom_range(0, 99) < 22) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    is_positive_i <= pos;
    slot_i <= slot;
    pixel_value_i <= pix;
    last_pixel_i <= last;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    if (op != OP_NONE) items_sent++;
    predict_item(op, pos, slot, pix, last);
  endtask

  function automatic logic [PIXEL_W-1:0] pattern_pixel(int pat, int k);
    int v;
    case (pat)
      PAT_ZERO:  v = 0;
      PAT_MAX:   v = 32767;
      PAT_MIN:   v = -32768;
      PAT_SMALL: v = int'($urandom_range(0, 400)) - 200;
      PAT_RAMP:  v = (k * 37) % 2000 - 1000;
      PAT_NRAMP: v = 1000 - (k * 37) % 2000;
      default:   v = int'($urandom_range(0, 65535));
    endcase
    return v[PIXEL_W-1:0];
  endfunction

  task automatic send_patch(opcode_e op, bit pos, logic [SLOT_W-1:0] slot,
                            int len, int pat);
    for (int k = 0; k < len; k++)
      send_item(op, pos, slot, pattern_pixel(pat, k), k == len - 1);
  endtask

  // Sample patch whose early pixels carry random opcodes and lists
  task automatic send_mixed_sample(int len);
    opcode_e op;
    for (int k = 0; k < len; k++) begin
      op = (k == len - 1) ? OP_SAMPLE : opcode_e'($urandom_range(0, 2));
      send_item(op, 1'($urandom), 7'($urandom), 16'($urandom), k == len - 1);
    end
  endtask

  // Write the threshold once the block has drained
  task automatic write_threshold(logic [SCORE_W-1:0] value);
    start_i <= 1'b0;
    do @(negedge clk_i); while (busy_o || expected_scores.size() != 0);
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    membership_threshold_we_i <= 1'b1;
    membership_threshold_i <= value;
    @(posedge clk_i);
    membership_threshold_we_i <= 1'b0;
    membership_threshold_i <= 16'($urandom);
    thresh = value;
  endtask

  // Result checker
  always @(negedge clk_i) begin
    score_t e;
    if (result_valid_o) begin
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = expected_scores.pop_front();
        if (status_o !== e.status || relative_score_o !== e.rel ||
            conservative_score_o !== e.cons || in_positive_o !== e.in_pos ||
            in_negative_o !== e.in_neg || closest_index_o !== e.idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp st=%0d rel=%0d cons=%0d ip=%0d in=%0d idx=%0d",
                     $realtime, e.status, e.rel, e.cons, e.in_pos, e.in_neg, e.idx,
                     " got st=%0d rel=%0d cons=%0d ip=%0d in=%0d idx=%0d",
                     status_o, relative_score_o, conservative_score_o,
                     in_positive_o, in_negative_o, closest_index_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(negedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("ncc_nearest_neighbor_patch_scorer_unit verification failed");
      $finish;
    end
  end

  // Empty lists: full sample, ignored opcode, short sample
  task automatic test_empty_lists();
    send_patch(OP_SAMPLE, 1'b0, '0, PP, PAT_RAMP);
    send_item(OP_NONE, 1'b1, 7'h7F, 16'hFFFF, 1'b1);
    send_patch(OP_SAMPLE, 1'b1, 7'd3, 3, PAT_RAMP);
  endtask

  // One overlong positive, no negatives
  task automatic test_single_positive();
    send_patch(OP_APPEND, 1'b1, '0, PP + 3, PAT_RAMP);
    send_patch(OP_SAMPLE, 1'b0, '0, 5, PAT_RAMP);
  endtask

  // Zero-norm negative by insert, slot errors on both lists
  task automatic test_template_edits();
    send_patch(OP_INSERT, 1'b0, 7'd0, PP, PAT_ZERO);
    send_patch(OP_INSERT, 1'b1, 7'd5, 2, PAT_RANDOM);
    send_patch(OP_INSERT, 1'b0, 7'd2, 1, PAT_RANDOM);
  endtask

  // Exact, partial, opposite-sign and extreme samples at threshold extremes
  task automatic test_sample_extremes();
    write_threshold(16'hFFFF);
    send_patch(OP_SAMPLE, 1'b0, '0, 4, PAT_RAMP);
    write_threshold(16'd0);
    send_patch(OP_SAMPLE, 1'b0, '0, 6, PAT_NRAMP);
    send_patch(OP_SAMPLE, 1'b0, '0, 3, PAT_MIN);
    send_patch(OP_SAMPLE, 1'b1, '0, 20, PAT_MAX);
    send_mixed_sample(12);
    write_threshold(16'd32768);
    send_patch(OP_SAMPLE, 1'b0, '0, 2, PAT_RANDOM);
    write_threshold(THRESH_RST);
  endtask

  // Random short samples, slot errors, ignored opcodes and threshold writes
  task automatic test_random_traffic();
    int  sel, base_items, cnt;
    bit  pos;
    base_items = items_sent;
    while (items_sent - base_items < RAND_ITEMS) begin
      gaps_on = ((items_sent - base_items) % 60) < 40;
      sel = $urandom_range(0, 99);
      pos = 1'($urandom);
      cnt = pos ? pos_cnt : neg_cnt;
      if (sel < 6) begin
        send_item(OP_NONE, 1'($urandom), 7'($urandom), 16'($urandom), 1'($urandom));
      end else if (sel < 14) begin
        send_patch(OP_INSERT, pos, 7'($urandom_range(cnt + 1, 127)),
                   $urandom_range(1, 3), PAT_RANDOM);
      end else if (sel < 30) begin
        send_mixed_sample($urandom_range(2, 10));
      end else if (sel < 33) begin
        write_threshold(16'($urandom));
      end else begin
        send_patch(OP_SAMPLE, 1'($urandom), 7'($urandom), $urandom_range(1, 20),
                   ($urandom_range(0, 3) == 0) ? PAT_SMALL : PAT_RANDOM);
      end
    end
    gaps_on = 1'b1;
  endtask

  // Fill the positive list with one-pixel templates and hit the full status;
  // these templates are only partly written, so no sample follows
  task automatic test_full_lists();
    gaps_on = 1'b0;
    while (pos_cnt < MT) begin
      if ($urandom_range(0, 1))
        send_patch(OP_APPEND, 1'b1, 7'($urandom), 1, PAT_RANDOM);
      else
        send_patch(OP_INSERT, 1'b1, 7'($urandom_range(0, pos_cnt)), 1, PAT_RANDOM);
    end
    gaps_on = 1'b1;
    send_patch(OP_APPEND, 1'b1, '0, 4, PAT_RANDOM);
    send_patch(OP_INSERT, 1'b1, 7'd127, 2, PAT_RANDOM);
    send_patch(OP_INSERT, 1'b0, 7'd127, 3, PAT_RANDOM);
  endtask

  initial begin
    thresh = THRESH_RST;
    pos_cnt = 0;
    neg_cnt = 0;
    pix_pos = 0;
    mismatches = 0;
    items_sent = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    for (int i = 0; i < MT * PP; i++) begin
      pos_store[i] = '0;
      neg_store[i] = '0;
    end
    for (int i = 0; i < PP; i++) smp_store[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lists();
    test_single_positive();
    test_template_edits();
    test_sample_extremes();
    test_random_traffic();
    test_full_lists();

    start_i <= 1'b0;
    do @(negedge clk_i); while (expected_scores.size() != 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("ncc_nearest_neighbor_patch_scorer_unit verification clean");
    end else begin
      $display("ncc_nearest_neighbor_patch_scorer_unit verification failed");
    end
    $finish;
  end

endmodule
